[sv/i2cms_pkg.sv]
`timescale 1ns / 1ps

package i2cms_pkg;

   // Default depth of the transmit buffer.
   localparam int unsigned BUF_DEPTH_DEF = 32;

   // Item kinds.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // Configuration register indexes.
   localparam logic REG_STOP_AT_END = 1'b0;
   localparam logic REG_NAK_AT_END  = 1'b1;

   // Controller control register bits.
   localparam logic [6:0] CTL_AA  = 7'h04;
   localparam logic [6:0] CTL_SI  = 7'h08;
   localparam logic [6:0] CTL_STO = 7'h10;
   localparam logic [6:0] CTL_STA = 7'h20;

   // Controller status codes.
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RESTART     = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
   localparam logic [7:0] ST_TX_DATA_ACK = 8'h28;
   localparam logic [7:0] ST_TX_DATA_NAK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
   localparam logic [7:0] ST_RX_DATA_ACK = 8'h50;
   localparam logic [7:0] ST_RX_DATA_NAK = 8'h58;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_TX   = 3'b010,
      MODE_RX   = 3'b100
   } mode_type;

   typedef struct packed {
      logic stop_at_end;
      logic nak_at_end;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] slave_address;
      logic [5:0] transfer_length;
      logic       read_not_write;
      logic [7:0] status_code;
   } item_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] target_address;
      logic [5:0] length;
      logic [5:0] position;
   } seq_state_type;

   typedef struct packed {
      logic       data_write_valid;
      logic [7:0] data_value;
      logic [6:0] control_set;
      logic [6:0] control_clear;
      logic       rx_valid;
      logic [4:0] rx_position;
      logic       transfer_done;
      logic [5:0] byte_count;
   } result_type;

endpackage

[sv/i2cms_if.sv]
`timescale 1ns / 1ps

interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [4:0] tx_index;
   logic [7:0] tx_value;
   logic [7:0] slave_address;
   logic [5:0] transfer_length;
   logic       read_not_write;
   logic [7:0] status_code;
   logic [7:0] rx_data;

   modport source (
      output valid, kind, tx_index, tx_value, slave_address, transfer_length,
             read_not_write, status_code, rx_data,
      input  ready
   );
   modport sink (
      input  valid, kind, tx_index, tx_value, slave_address, transfer_length,
             read_not_write, status_code, rx_data,
      output ready
   );
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       data_write_valid;
   logic [7:0] data_value;
   logic [6:0] control_set;
   logic [6:0] control_clear;
   logic       rx_valid;
   logic [4:0] rx_position;
   logic       transfer_done;
   logic [5:0] byte_count;

   modport source (
      output valid, data_write_valid, data_value, control_set, control_clear,
             rx_valid, rx_position, transfer_done, byte_count,
      input  ready
   );
   modport sink (
      input  valid, data_write_valid, data_value, control_set, control_clear,
             rx_valid, rx_position, transfer_done, byte_count,
      output ready
   );
endinterface

[sv/i2cms_ram.sv]
`timescale 1ns / 1ps

module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/i2cms_seq.sv]
`timescale 1ns / 1ps

module i2cms_seq #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
   input  i2cms_pkg::item_type      item,
   input  i2cms_pkg::seq_state_type state,
   input  i2cms_pkg::cfg_type       cfg,
   input  logic [7:0]               tx_byte,
   output i2cms_pkg::seq_state_type state_next,
   output i2cms_pkg::result_type    result
);

   localparam int LEN_CAP = (BUF_DEPTH > 63) ? 63 : BUF_DEPTH;
   localparam logic [5:0] LEN_MAX = 6'(LEN_CAP);

   logic [5:0] pos_eff;
   logic       finish;

   always_comb begin
      state_next = state;
      result     = '0;
      finish     = 1'b0;
      pos_eff    = state.position;

      case (item.kind)
         i2cms_pkg::KIND_START: begin
            if (state.mode == i2cms_pkg::MODE_IDLE) begin
               state_next.target_address = item.slave_address;
               state_next.length   = (item.transfer_length > LEN_MAX) ? LEN_MAX
                                                                      : item.transfer_length;
               state_next.position = '0;
               state_next.mode     = item.read_not_write ? i2cms_pkg::MODE_RX
                                                         : i2cms_pkg::MODE_TX;
               result.control_clear = i2cms_pkg::CTL_AA | i2cms_pkg::CTL_SI;
               result.control_set   = i2cms_pkg::CTL_STA;
            end
         end
         i2cms_pkg::KIND_EVENT: begin
            case (state.mode)
               i2cms_pkg::MODE_TX: begin
                  case (item.status_code)
                     i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_ARB_LOST: begin
                        result.control_clear = i2cms_pkg::CTL_AA;
                        result.control_set   = i2cms_pkg::CTL_STA;
                     end
                     i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
                        result.data_write_valid = 1'b1;
                        result.data_value    = {state.target_address[7:1], 1'b0};
                        result.control_clear = i2cms_pkg::CTL_AA | i2cms_pkg::CTL_STA;
                     end
                     i2cms_pkg::ST_TX_DATA_NAK, i2cms_pkg::ST_SLA_W_ACK,
                     i2cms_pkg::ST_TX_DATA_ACK: begin
                        // A NACKed byte is sent again from one position back.
                        if (item.status_code == i2cms_pkg::ST_TX_DATA_NAK &&
                            state.position != '0) begin
                           pos_eff = state.position - 6'd1;
                        end
                        if (pos_eff < state.length) begin
                           result.data_write_valid = 1'b1;
                           result.data_value    = tx_byte;
                           state_next.position  = pos_eff + 6'd1;
                           result.control_clear = i2cms_pkg::CTL_STA;
                           result.control_set   = i2cms_pkg::CTL_AA;
                        end else begin
                           state_next.position = pos_eff;
                           finish = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               i2cms_pkg::MODE_RX: begin
                  case (item.status_code)
                     i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_SLA_R_NACK: begin
                        result.control_clear = i2cms_pkg::CTL_AA;
                        result.control_set   = i2cms_pkg::CTL_STA;
                     end
                     i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART: begin
                        result.data_write_valid = 1'b1;
                        result.data_value    = {state.target_address[7:1], 1'b1};
                        result.control_clear = i2cms_pkg::CTL_AA | i2cms_pkg::CTL_STA;
                     end
                     i2cms_pkg::ST_SLA_R_ACK: begin
                        result.control_clear = i2cms_pkg::CTL_STA;
                        result.control_set   = i2cms_pkg::CTL_AA;
                     end
                     i2cms_pkg::ST_RX_DATA_ACK: begin
                        if (state.position < state.length) begin
                           result.rx_valid      = 1'b1;
                           result.rx_position   = state.position[4:0];
                           state_next.position  = state.position + 6'd1;
                           result.control_clear = i2cms_pkg::CTL_STA;
                           result.control_set   = i2cms_pkg::CTL_AA;
                        end else begin
                           finish = 1'b1;
                        end
                     end
                     i2cms_pkg::ST_RX_DATA_NAK: begin
                        finish = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase

            if (finish) begin
               result.control_clear = (cfg.stop_at_end && cfg.nak_at_end)
                                      ? i2cms_pkg::CTL_STA
                                      : (i2cms_pkg::CTL_STA | i2cms_pkg::CTL_AA);
               result.control_set   = cfg.stop_at_end ? i2cms_pkg::CTL_STO : '0;
               result.transfer_done = 1'b1;
               state_next.mode      = i2cms_pkg::MODE_IDLE;
            end
            result.control_clear = result.control_clear | i2cms_pkg::CTL_SI;
         end
         default: begin
         end
      endcase

      result.byte_count = state_next.position;
   end

endmodule

[sv/i2c_master_transfer_sequencer.sv]
`timescale 1ns / 1ps
// An item enters the input register when it is accepted; its result enters the result
// register when the item moves on, which waits while a full result register is stalled.
// Throughput: one item per cycle unless results stall; the buffer read is issued on accept.
// Reset: input not ready, stop_at_end 0, nak_at_end 1, idle, position, length, address zero.
// The transmit buffer holds no reset value; an entry reads valid only after a load.

module i2c_master_transfer_sequencer #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   i2cms_req_if.sink     req_bus,
   i2cms_rsp_if.source   rsp_bus,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic          csr_write_data
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   i2cms_pkg::cfg_type       cfg_ff;
   i2cms_pkg::item_type      item_ff;
   logic                     item_valid_ff;
   i2cms_pkg::seq_state_type state_ff;
   i2cms_pkg::seq_state_type state_in;
   i2cms_pkg::result_type    rsp_ff;
   i2cms_pkg::result_type    rsp_in;
   logic                     rsp_valid_ff;

   logic          adv;
   logic          req_fire;
   logic [5:0]    pos_base;
   logic [5:0]    rd_pos;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [7:0]    tx_byte;

   // The item register moves on when the result register is free or being drained.
   assign adv           = item_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!item_valid_ff || adv);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // The buffer read is aimed at the position this item will see, after the item
   // ahead of it has been processed, one step back for a NACKed data byte.
   assign pos_base = adv ? state_in.position : state_ff.position;
   assign rd_pos   = (req_bus.status_code == i2cms_pkg::ST_TX_DATA_NAK && pos_base != '0)
                     ? pos_base - 6'd1 : pos_base;
   assign rd_addr  = AW'(rd_pos);
   assign wr_en    = req_fire && req_bus.kind == i2cms_pkg::KIND_LOAD &&
                     32'(req_bus.tx_index) < BUF_DEPTH;

   i2cms_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_tx_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_bus.tx_index)),
      .wr_data (req_bus.tx_value),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (tx_byte)
   );

   i2cms_seq #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_seq (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .tx_byte    (tx_byte),
      .state_next (state_in),
      .result     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_at_end <= 1'b0;
         cfg_ff.nak_at_end  <= 1'b1;
         item_valid_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.mode           <= i2cms_pkg::MODE_IDLE;
         state_ff.target_address <= '0;
         state_ff.length         <= '0;
         state_ff.position       <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               i2cms_pkg::REG_STOP_AT_END: cfg_ff.stop_at_end <= csr_write_data;
               i2cms_pkg::REG_NAK_AT_END:  cfg_ff.nak_at_end  <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (req_bus.ready) begin
            item_valid_ff <= req_bus.valid;
         end
         if (adv) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.kind            <= req_bus.kind;
         item_ff.slave_address   <= req_bus.slave_address;
         item_ff.transfer_length <= req_bus.transfer_length;
         item_ff.read_not_write  <= req_bus.read_not_write;
         item_ff.status_code     <= req_bus.status_code;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.data_write_valid = rsp_ff.data_write_valid;
   assign rsp_bus.data_value       = rsp_ff.data_value;
   assign rsp_bus.control_set      = rsp_ff.control_set;
   assign rsp_bus.control_clear    = rsp_ff.control_clear;
   assign rsp_bus.rx_valid         = rsp_ff.rx_valid;
   assign rsp_bus.rx_position      = rsp_ff.rx_position;
   assign rsp_bus.transfer_done    = rsp_ff.transfer_done;
   assign rsp_bus.byte_count       = rsp_ff.byte_count;

   // The position never runs past the latched length.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.position <= state_ff.length)
      else $error("position beyond transfer length");

   // A processed item always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      adv |=> rsp_valid_ff)
      else $error("processed item lost its result beat");

   // A new beat is taken only when the item register is free or moving on.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!item_valid_ff || adv))
      else $error("item register overwritten");

   // A finishing step neither writes data nor accepts a received byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.transfer_done) |-> (!rsp_ff.data_write_valid && !rsp_ff.rx_valid))
      else $error("finishing step with data activity");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import i2cms_pkg::*;

   localparam int BUF_DEPTH = BUF_DEPTH_DEF;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_BEATS = 1250;
   localparam int HOLD_CYCLES = 300;
   localparam logic [7:0] STATUS_CODES [11] = '{
      ST_START, ST_RESTART, ST_SLA_W_ACK, ST_SLA_W_NACK, ST_TX_DATA_ACK, ST_TX_DATA_NAK,
      ST_ARB_LOST, ST_SLA_R_ACK, ST_SLA_R_NACK, ST_RX_DATA_ACK, ST_RX_DATA_NAK
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] tx_index;
      logic [7:0] tx_value;
      logic [7:0] slave_address;
      logic [5:0] transfer_length;
      logic       read_not_write;
      logic [7:0] status_code;
      logic [7:0] rx_data;
   } request_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic csr_write_data;

   i2cms_req_if req_bus ();
   i2cms_rsp_if rsp_bus ();

   i2c_master_transfer_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the sequencer: configuration, transfer state and transmit buffer.
   logic       cfg_stop = 1'b0;
   logic       cfg_nak = 1'b1;
   mode_type   seq_mode = MODE_IDLE;
   logic [7:0] seq_addr = '0;
   logic [5:0] seq_len = '0;
   logic [5:0] seq_pos = '0;
   logic [7:0] tx_shadow [BUF_DEPTH];
   bit         loaded [BUF_DEPTH];

   result_type pending_results [$];
   int beats_sent = 0;
   int results_checked = 0;
   int transfers_closed = 0;
   int mismatches = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("timeout with %0d results still pending", pending_results.size());
      $display("status: fail");
      $finish;
   end

   function automatic void close_transfer(inout logic [6:0] clr_m, inout logic [6:0] set_m);
      clr_m |= (cfg_stop && cfg_nak) ? CTL_STA : (CTL_STA | CTL_AA);
      if (cfg_stop)
         set_m |= CTL_STO;
      seq_mode = MODE_IDLE;
      transfers_closed++;
   endfunction

   // Advances the shadow by one accepted beat and returns the result it must produce.
   function automatic result_type sequence_step(input request_type b);
      result_type r;
      logic [6:0] set_m;
      logic [6:0] clr_m;
      r = '0;
      set_m = '0;
      clr_m = '0;
      case (b.kind)
         KIND_LOAD: begin
            tx_shadow[b.tx_index] = b.tx_value;
            loaded[b.tx_index] = 1'b1;
         end
         KIND_START: begin
            if (seq_mode == MODE_IDLE) begin
               seq_addr = b.slave_address;
               seq_len = (b.transfer_length > BUF_DEPTH) ? 6'(BUF_DEPTH) : b.transfer_length;
               seq_pos = '0;
               seq_mode = b.read_not_write ? MODE_RX : MODE_TX;
               clr_m = CTL_AA | CTL_SI;
               set_m = CTL_STA;
            end
         end
         KIND_EVENT: begin
            if (seq_mode == MODE_TX) begin
               case (b.status_code)
                  ST_SLA_W_NACK, ST_ARB_LOST: begin
                     clr_m = CTL_AA;
                     set_m = CTL_STA;
                  end
                  ST_START, ST_RESTART: begin
                     r.data_write_valid = 1'b1;
                     r.data_value = seq_addr & 8'hFE;
                     clr_m = CTL_AA | CTL_STA;
                  end
                  ST_TX_DATA_NAK, ST_SLA_W_ACK, ST_TX_DATA_ACK: begin
                     // A NACKed byte is sent again, so the position steps back first.
                     if (b.status_code == ST_TX_DATA_NAK && seq_pos > 0)
                        seq_pos = seq_pos - 1'b1;
                     if (seq_pos < seq_len && seq_pos < BUF_DEPTH) begin
                        r.data_write_valid = 1'b1;
                        r.data_value = tx_shadow[seq_pos[4:0]];
                        seq_pos = seq_pos + 1'b1;
                        clr_m = CTL_STA;
                        set_m = CTL_AA;
                     end else begin
                        close_transfer(clr_m, set_m);
                        r.transfer_done = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else if (seq_mode == MODE_RX) begin
               case (b.status_code)
                  ST_ARB_LOST, ST_SLA_R_NACK: begin
                     clr_m = CTL_AA;
                     set_m = CTL_STA;
                  end
                  ST_START, ST_RESTART: begin
                     r.data_write_valid = 1'b1;
                     r.data_value = seq_addr | 8'h01;
                     clr_m = CTL_AA | CTL_STA;
                  end
                  ST_SLA_R_ACK: begin
                     clr_m = CTL_STA;
                     set_m = CTL_AA;
                  end
                  ST_RX_DATA_ACK: begin
                     if (seq_pos < seq_len) begin
                        r.rx_valid = 1'b1;
                        r.rx_position = seq_pos[4:0];
                        seq_pos = seq_pos + 1'b1;
                        clr_m = CTL_STA;
                        set_m = CTL_AA;
                     end else begin
                        close_transfer(clr_m, set_m);
                        r.transfer_done = 1'b1;
                     end
                  end
                  ST_RX_DATA_NAK: begin
                     close_transfer(clr_m, set_m);
                     r.transfer_done = 1'b1;
                  end
                  default: ;
               endcase
            end
            clr_m |= CTL_SI;
         end
         default: ;
      endcase
      r.control_set = set_m;
      r.control_clear = clr_m;
      r.byte_count = seq_pos;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [5:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 6'($urandom_range(0, 6));
      if (r < 92)
         return 6'($urandom_range(7, 32));
      return 6'($urandom_range(33, 63));
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic request_type random_beat();
      request_type b;
      b.kind = 2'($urandom_range(0, 3));
      b.tx_index = 5'($urandom);
      b.tx_value = 8'($urandom);
      b.slave_address = 8'($urandom);
      b.transfer_length = 6'($urandom);
      b.read_not_write = 1'($urandom);
      b.status_code = 8'($urandom);
      b.rx_data = 8'($urandom);
      return b;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Drives one request beat, waits for it to be taken and records its result.
   task automatic send_item(input request_type b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind <= b.kind;
      req_bus.tx_index <= b.tx_index;
      req_bus.tx_value <= b.tx_value;
      req_bus.slave_address <= b.slave_address;
      req_bus.transfer_length <= b.transfer_length;
      req_bus.read_not_write <= b.read_not_write;
      req_bus.status_code <= b.status_code;
      req_bus.rx_data <= b.rx_data;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(sequence_step(b));
      beats_sent++;
   endtask

   task automatic load_byte(input logic [4:0] idx, input logic [7:0] value);
      request_type b;
      b = random_beat();
      b.kind = KIND_LOAD;
      b.tx_index = idx;
      b.tx_value = value;
      send_item(b);
   endtask

   // Status beats that would send a buffer entry never loaded get a load first.
   task automatic send_event(input request_type b);
      logic [5:0] next_pos;
      next_pos = seq_pos;
      if (seq_mode == MODE_TX && (b.status_code == ST_SLA_W_ACK ||
          b.status_code == ST_TX_DATA_ACK || b.status_code == ST_TX_DATA_NAK)) begin
         if (b.status_code == ST_TX_DATA_NAK && next_pos > 0)
            next_pos = next_pos - 1'b1;
         if (next_pos < seq_len && !loaded[next_pos[4:0]])
            load_byte(next_pos[4:0], rand_byte());
      end
      send_item(b);
   endtask

   task automatic status(input logic [7:0] code, input logic [7:0] rxd);
      request_type b;
      b = random_beat();
      b.kind = KIND_EVENT;
      b.status_code = code;
      b.rx_data = rxd;
      send_event(b);
   endtask

   task automatic start_transfer(input logic [7:0] addr, input logic [5:0] len, input logic rnw);
      request_type b;
      b = random_beat();
      b.kind = KIND_START;
      b.slave_address = addr;
      b.transfer_length = len;
      b.read_not_write = rnw;
      send_item(b);
   endtask

   task automatic send_noise();
      request_type b;
      b = random_beat();
      if (b.kind == KIND_EVENT) begin
         if ($urandom_range(0, 1))
            b.status_code = STATUS_CODES[$urandom_range(0, 10)];
         send_event(b);
      end else begin
         send_item(b);
      end
   endtask

   task automatic close_open_transfer();
      while (seq_mode != MODE_IDLE)
         status((seq_mode == MODE_RX) ? ST_RX_DATA_NAK : ST_TX_DATA_ACK, rand_byte());
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      if (idx == REG_STOP_AT_END)
         cfg_stop = value;
      else
         cfg_nak = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_write_transfer();
      int r;
      close_open_transfer();
      for (int i = 0; i < BUF_DEPTH; i++) begin
         if ($urandom_range(0, 7) == 0)
            load_byte(5'(i), rand_byte());
      end
      start_transfer(rand_byte(), pick_length(), 1'b0);
      status(ST_START, rand_byte());
      if ($urandom_range(0, 99) < 20) begin
         status(ST_SLA_W_NACK, rand_byte());
         status(ST_RESTART, rand_byte());
      end
      status(ST_SLA_W_ACK, rand_byte());
      while (seq_mode == MODE_TX) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            status(ST_TX_DATA_ACK, rand_byte());
         end else if (r < 80) begin
            status(ST_TX_DATA_NAK, rand_byte());
         end else if (r < 85) begin
            status(ST_ARB_LOST, rand_byte());
            status(ST_RESTART, rand_byte());
         end else if (r < 92) begin
            load_byte(5'($urandom), rand_byte());
         end else begin
            send_noise();
         end
      end
   endtask

   task automatic run_read_transfer();
      int r;
      close_open_transfer();
      start_transfer(rand_byte(), pick_length(), 1'b1);
      status(ST_START, rand_byte());
      if ($urandom_range(0, 99) < 15) begin
         status(ST_SLA_R_NACK, rand_byte());
         status(ST_RESTART, rand_byte());
      end
      status(ST_SLA_R_ACK, rand_byte());
      while (seq_mode == MODE_RX) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            status(ST_RX_DATA_ACK, rand_byte());
         end else if (r < 85) begin
            status(ST_RX_DATA_NAK, rand_byte());
         end else if (r < 90) begin
            status(ST_ARB_LOST, rand_byte());
            status(ST_RESTART, rand_byte());
            status(ST_SLA_R_ACK, rand_byte());
         end else if (r < 95) begin
            load_byte(5'($urandom), rand_byte());
         end else begin
            send_noise();
         end
      end
   endtask

   // Reset defaults first, then a NACKed address, a resent byte and a lost arbitration.
   task automatic test_transmit_directed();
      request_type b;
      load_byte(5'd0, 8'h00);
      load_byte(5'd1, 8'hFF);
      load_byte(5'd31, 8'hA5);
      start_transfer(8'hFF, 6'd2, 1'b0);
      status(ST_START, 8'h00);
      status(ST_SLA_W_NACK, 8'hFF);
      status(ST_RESTART, 8'h00);
      status(ST_SLA_W_ACK, 8'h00);
      status(ST_TX_DATA_NAK, 8'h00);
      status(8'hFF, 8'hFF);
      status(ST_TX_DATA_ACK, 8'h00);
      status(ST_ARB_LOST, 8'h00);
      status(ST_TX_DATA_ACK, 8'h00);
      settle();
      write_register(REG_STOP_AT_END, 1'b1);
      write_register(REG_NAK_AT_END, 1'b1);
      // Zero-length write; a NACK at position zero must not wrap the position.
      start_transfer(8'h5A, 6'd0, 1'b0);
      status(ST_START, 8'h00);
      status(ST_TX_DATA_NAK, 8'h00);
      b = random_beat();
      b.kind = KIND_SPARE;
      send_item(b);
      status(ST_RX_DATA_ACK, 8'hFF);
      settle();
   endtask

   task automatic test_receive_directed();
      write_register(REG_NAK_AT_END, 1'b0);
      start_transfer(8'h00, 6'd40, 1'b1);
      status(ST_START, 8'h00);
      status(ST_SLA_R_NACK, 8'h00);
      status(ST_RESTART, 8'h00);
      status(ST_SLA_R_ACK, 8'h00);
      status(ST_RX_DATA_ACK, 8'hFF);
      status(ST_RX_DATA_ACK, 8'h00);
      start_transfer(8'h3C, 6'd1, 1'b0);
      status(ST_RX_DATA_NAK, 8'h00);
      settle();
   endtask

   // The receiver holds off while the sender keeps offering beats back to back.
   task automatic test_backpressure();
      quiet = 1'b1;
      hold_request = 1'b1;
      for (int i = 0; i < 24; i++)
         load_byte(5'(i), rand_byte());
      run_read_transfer();
      run_write_transfer();
      quiet = 1'b0;
      settle();
   endtask

   task automatic test_sender_pause();
      close_open_transfer();
      start_transfer(rand_byte(), 6'd4, 1'b0);
      status(ST_START, rand_byte());
      status(ST_SLA_W_ACK, rand_byte());
      settle();
      close_open_transfer();
      settle();
   endtask

   task automatic test_random_traffic();
      int phase;
      int target;
      int r;
      phase = 0;
      target = beats_sent + RANDOM_BEATS;
      while (beats_sent < target) begin
         settle();
         case (phase)
            0: begin
               write_register(REG_STOP_AT_END, 1'b0);
               write_register(REG_NAK_AT_END, 1'b0);
            end
            1: write_register(REG_STOP_AT_END, 1'b1);
            2: write_register(REG_NAK_AT_END, 1'b1);
            3: write_register(REG_STOP_AT_END, 1'b0);
            default: begin
               write_register(REG_STOP_AT_END, 1'($urandom));
               write_register(REG_NAK_AT_END, 1'($urandom));
            end
         endcase
         quiet = (phase % 5 == 2);
         repeat (12) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               run_write_transfer();
            else if (r < 85)
               run_read_transfer();
            else
               repeat ($urandom_range(1, 4)) send_noise();
         end
         phase++;
      end
      quiet = 1'b0;
      close_open_transfer();
      settle();
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++)
               @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 99) < 20) begin
            rsp_bus.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
                                                       $urandom_range(0, 2);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      result_type seen;
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.data_write_valid = rsp_bus.data_write_valid;
            seen.data_value = rsp_bus.data_value;
            seen.control_set = rsp_bus.control_set;
            seen.control_clear = rsp_bus.control_clear;
            seen.rx_valid = rsp_bus.rx_valid;
            seen.rx_position = rsp_bus.rx_position;
            seen.transfer_done = rsp_bus.transfer_done;
            seen.byte_count = rsp_bus.byte_count;
            if (pending_results.size() == 0) begin
               $display("%0t ns: result beat with nothing pending, actual 0x%0h", $time, seen);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("data_write_valid", 8'(want.data_write_valid),
                           8'(seen.data_write_valid));
               check_field("data_value", want.data_value, seen.data_value);
               check_field("control_set", 8'(want.control_set), 8'(seen.control_set));
               check_field("control_clear", 8'(want.control_clear), 8'(seen.control_clear));
               check_field("rx_valid", 8'(want.rx_valid), 8'(seen.rx_valid));
               check_field("rx_position", 8'(want.rx_position), 8'(seen.rx_position));
               check_field("transfer_done", 8'(want.transfer_done), 8'(seen.transfer_done));
               check_field("byte_count", 8'(want.byte_count), 8'(seen.byte_count));
               results_checked++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_LOAD;
      req_bus.tx_index = '0;
      req_bus.tx_value = '0;
      req_bus.slave_address = '0;
      req_bus.transfer_length = '0;
      req_bus.read_not_write = 1'b0;
      req_bus.status_code = '0;
      req_bus.rx_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_transmit_directed();
      test_receive_directed();
      test_backpressure();
      test_sender_pause();
      test_random_traffic();
      repeat (20) @(posedge clock);

      $display("Sent %0d request beats and checked %0d results across %0d closed transfers.",
               beats_sent, results_checked, transfers_closed);
      $display("All stop/NACK settings, address NACKs, resends, lost arbitration and stalls ran.");
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
